[src/qrlt_pkg.sv]
// Shared types, codes and sizes for the quorum replica lock table.
// No dependencies; every other file imports this package.
package qrlt_pkg;

  // sizes
  localparam int MAX_REPLICAS = 16;
  localparam int CLIENT_BITS  = 8;
  localparam int CLIENT_W     = 8;   // width of the client_id port
  localparam int CFG_W        = 5;   // widest configuration register
  localparam int TALLY_W      = 5;
  localparam int POS_W        = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
  // width wide enough to compare a ring position, a count and MAX_REPLICAS
  localparam int CMP_W        = ((POS_W > CFG_W) ? POS_W : CFG_W) + 2;

  // action codes
  localparam logic [1:0] ACT_LOCK  = 2'd0;
  localparam logic [1:0] ACT_CHECK = 2'd1;
  localparam logic [1:0] ACT_PLACE = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  // lock kinds
  localparam logic [1:0] KIND_UNLOCKED = 2'd0;
  localparam logic [1:0] KIND_READ     = 2'd1;
  localparam logic [1:0] KIND_WRITE    = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_MISS   = 2'd1;
  localparam logic [1:0] ST_BADIDX = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_READ_Q  = 2'd0;
  localparam logic [1:0] CFG_WRITE_Q = 2'd1;
  localparam logic [1:0] CFG_COUNT   = 2'd2;

  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  // one replica entry as held in a cell
  typedef struct packed {
    logic [1:0]             lock;
    logic [CLIENT_BITS-1:0] owner;
    logic                   placed;
    logic                   up;
  } entry_t;

  // saturating tally increment
  function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] t);
    return (t == TALLY_MAX) ? t : t + TALLY_W'(1);
  endfunction

  // fit a client id into the owner field, low bits kept
  function automatic logic [CLIENT_BITS-1:0] to_owner(input logic [CLIENT_W-1:0] c);
    logic [CLIENT_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < CLIENT_BITS; i++) begin
      if (i < CLIENT_W) r[i] = c[i];
    end
    return r;
  endfunction

endpackage

[src/quorum_replica_lock_table.sv]
// Top level of the quorum replica lock table: control sequencer and the
// ring of qrlt_cell entries. Depends on qrlt_pkg and qrlt_cell.
//
// Usage. A command word is taken at a rising edge with start high and busy
// low: action, lock_kind, client_id, replica_index, placed, available.
// Each command gives one result word (status, replica_tally), shown for
// exactly one cycle with done high; the receiver cannot stall it.
// Configuration: cfg_we, cfg_index, cfg_data write read_quorum (0),
// write_quorum (1) or replica_count (2), one per write; write only when idle.
// Timing. The entries rotate through a ring of MAX_REPLICAS cells; the cell
// at the head is examined and rewritten as it passes, one entry a cycle.
// A granted read or write lock takes two full turns of the ring (count,
// then update) before done rises. Unlock, quorum check, good placement
// and a refused lock take one turn. A bad placement index or action three
// answers in the next cycle. busy falls with done, so a new word can be
// accepted in the cycle the result is shown.
// Reset (rst, synchronous) clears all entries, quorums to one, count to 0.
module quorum_replica_lock_table (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action,
  input  logic [1:0]                   lock_kind,
  input  logic [qrlt_pkg::CLIENT_W-1:0] client_id,
  input  logic [3:0]                   replica_index,
  input  logic                         placed,
  input  logic                         available,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [qrlt_pkg::TALLY_W-1:0] replica_tally,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [qrlt_pkg::CFG_W-1:0]   cfg_data
);
  import qrlt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_COUNT  = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  state_t state;

  // configuration
  logic [CFG_W-1:0] read_quorum, write_quorum, replica_count;

  // latched command word
  logic [1:0]             act_q, kind_q;
  logic [CLIENT_BITS-1:0] owner_q;
  logic [3:0]             idx_q;
  logic                   placed_q, up_q;
  logic [CFG_W-1:0]       quorum_q;

  logic [POS_W-1:0]   pos;
  logic [TALLY_W-1:0] tally_q, tally_next;

  entry_t ring [MAX_REPLICAS];
  entry_t head, head_next;
  logic   shift;

  // entries in use: a count above the table size means none
  logic [CMP_W-1:0] n_ext, pos_ext, idx_ext;
  logic             in_use, last, idx_ok;
  logic [1:0]       kind_n;

  assign n_ext   = (CMP_W'(replica_count) > CMP_W'(MAX_REPLICAS)) ? '0
                                                                  : CMP_W'(replica_count);
  assign pos_ext = CMP_W'(pos);
  assign idx_ext = CMP_W'(idx_q);
  assign in_use  = pos_ext < n_ext;
  assign last    = pos == POS_W'(MAX_REPLICAS - 1);
  assign idx_ok  = CMP_W'(replica_index) < n_ext;
  assign kind_n  = (lock_kind > KIND_WRITE) ? KIND_WRITE : lock_kind;

  assign busy  = state != S_IDLE;
  assign shift = busy;
  assign head  = ring[0];

  // ring of cells: entries move towards the head, the rewritten head
  // re-enters at the tail
  for (genvar i = 0; i < MAX_REPLICAS; i++) begin : g_cell
    if (i == MAX_REPLICAS - 1) begin : g_tail
      qrlt_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (shift),
        .entry_in (head_next),
        .entry_q  (ring[i])
      );
    end else begin : g_body
      qrlt_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (shift),
        .entry_in (ring[i+1]),
        .entry_q  (ring[i])
      );
    end
  end

  // head examination and rewrite
  always_comb begin
    head_next  = head;
    tally_next = tally_q;
    if (in_use) begin
      if (state == S_COUNT) begin
        // free entries for a lock request
        if (head.lock == KIND_UNLOCKED && head.placed && head.up)
          tally_next = sat_inc(tally_q);
      end else if (state == S_UPDATE) begin
        unique case (act_q)
          ACT_LOCK: begin
            if (kind_q == KIND_UNLOCKED) begin
              if (head.placed && head.up) begin
                head_next.lock  = KIND_UNLOCKED;
                head_next.owner = '0;
                tally_next      = sat_inc(tally_q);
              end
            end else if (head.lock == KIND_UNLOCKED && head.placed && head.up) begin
              head_next.lock  = kind_q;
              head_next.owner = owner_q;
            end
          end
          ACT_CHECK: begin
            // live holders count, holders that are down lose the lock
            if (head.lock == kind_q && head.placed) begin
              if (head.up) tally_next = sat_inc(tally_q);
              else         head_next.lock = KIND_UNLOCKED;
            end
          end
          ACT_PLACE: begin
            if (pos_ext == idx_ext) begin
              head_next.placed = placed_q;
              head_next.up     = up_q;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // sequencer, configuration and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      pos           <= '0;
      tally_q       <= '0;
      read_quorum   <= CFG_W'(1);
      write_quorum  <= CFG_W'(1);
      replica_count <= '0;
    end else begin
      done <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_READ_Q:  read_quorum   <= cfg_data;
          CFG_WRITE_Q: write_quorum  <= cfg_data;
          CFG_COUNT:   replica_count <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            act_q    <= action;
            kind_q   <= kind_n;
            owner_q  <= to_owner(client_id);
            idx_q    <= replica_index;
            placed_q <= placed;
            up_q     <= available;
            quorum_q <= (kind_n == KIND_READ) ? read_quorum : write_quorum;
            tally_q  <= '0;
            pos      <= '0;
            if (action == ACT_NONE) begin
              done          <= 1'b1;
              status        <= ST_MISS;
              replica_tally <= '0;
            end else if (action == ACT_PLACE && !idx_ok) begin
              done          <= 1'b1;
              status        <= ST_BADIDX;
              replica_tally <= '0;
            end else if (action == ACT_LOCK && kind_n != KIND_UNLOCKED) begin
              state <= S_COUNT;
            end else begin
              state <= S_UPDATE;
            end
          end
        end
        S_COUNT: begin
          tally_q <= tally_next;
          pos     <= pos + POS_W'(1);
          if (last) begin
            pos <= '0;
            if (CFG_W'(tally_next) >= quorum_q) begin
              state <= S_UPDATE;
            end else begin
              state         <= S_IDLE;
              done          <= 1'b1;
              status        <= ST_MISS;
              replica_tally <= tally_next;
            end
          end
        end
        S_UPDATE: begin
          tally_q <= tally_next;
          pos     <= pos + POS_W'(1);
          if (last) begin
            pos   <= '0;
            state <= S_IDLE;
            done  <= 1'b1;
            if (act_q == ACT_CHECK)
              status <= (CFG_W'(tally_next) >= quorum_q) ? ST_OK : ST_MISS;
            else
              status <= ST_OK;
            replica_tally <= (act_q == ACT_PLACE) ? '0 : tally_next;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/qrlt_cell.sv]
// One cell of the replica ring: holds a single entry and takes its
// neighbour's entry whenever the ring shifts. Depends on qrlt_pkg.
module qrlt_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  qrlt_pkg::entry_t entry_in,
  output qrlt_pkg::entry_t entry_q
);
  import qrlt_pkg::*;

  // entry register, cleared to unlocked / unplaced at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_q <= '0;
    end else if (shift) begin
      entry_q <= entry_in;
    end
  end

endmodule

[src/qrlt_checker.sv]
// Port-level checks for quorum_replica_lock_table, attached by bind.
// Depends on qrlt_pkg.
module qrlt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic [1:0]                   action,
  input logic                         done,
  input logic [1:0]                   status,
  input logic [qrlt_pkg::TALLY_W-1:0] replica_tally
);
  import qrlt_pkg::*;

  // a result word only appears once the sequencer has let go
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // action three answers at once as a miss with no tally
  a_none_fast: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_NONE) |=>
      (done && status == ST_MISS && replica_tally == '0))
    else $error("ignored action not answered as a miss");

  // lock, unlock and check always walk the ring
  a_walk: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action == ACT_LOCK || action == ACT_CHECK)) |=>
      (busy && !done))
    else $error("request did not start a ring pass");

  // a bad index carries no tally
  a_badidx: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_BADIDX) |-> (replica_tally == '0))
    else $error("bad index result with non-zero tally");

  // status code three is never produced
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_MISS || status == ST_BADIDX))
    else $error("undefined status code");

endmodule

bind quorum_replica_lock_table qrlt_checker u_qrlt_checker (.*);
